@@ rtl/core/dpfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Doorbell pulse frame decoder package
// Shared types, status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package dpfd_pkg;

  localparam int CODE_BITS  = 12;
  localparam int INDEX_BITS = 5;
  localparam int THR_BITS   = 12;
  localparam int SCALE_BITS = 8;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [INDEX_BITS-1:0] FRAME_PULSES = 5'd26;
  localparam logic [INDEX_BITS-1:0] INDEX_MAX    = 5'd31;
  localparam logic [INDEX_BITS-1:0] START_PULSE  = 5'd1;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_COUNT = 3'd1,
    ST_START = 3'd2,
    ST_SHORT = 3'd3,
    ST_MANCH = 3'd4,
    ST_LONG  = 3'd5,
    ST_ZERO  = 3'd6
  } status_t;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_SCALE     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_MAX        = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_LONG_SPLIT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_MIN        = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_MIN         = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_MAX         = 3'd5;

  localparam logic [SCALE_BITS-1:0] RST_SAMPLE_SCALE     = 8'd1;
  localparam logic [THR_BITS-1:0]   RST_START_MAX        = 12'd425;
  localparam logic [THR_BITS-1:0]   RST_SHORT_LONG_SPLIT = 12'd350;
  localparam logic [THR_BITS-1:0]   RST_SHORT_MIN        = 12'd150;
  localparam logic [THR_BITS-1:0]   RST_LONG_MIN         = 12'd450;
  localparam logic [THR_BITS-1:0]   RST_LONG_MAX         = 12'd650;

  typedef struct packed {
    logic [SCALE_BITS-1:0] sample_scale;
    logic [THR_BITS-1:0]   start_max;
    logic [THR_BITS-1:0]   short_long_split;
    logic [THR_BITS-1:0]   short_min;
    logic [THR_BITS-1:0]   long_min;
    logic [THR_BITS-1:0]   long_max;
  } cfg_t;

  typedef struct packed {
    status_t pair_err;
    logic    bit_one;
    logic    start_long;
  } eval_t;

endpackage

@@ rtl/core/dpfd_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the sample scale and the pulse window thresholds.
// ----------------------------------------------------------------------------
module dpfd_cfg_regs
  import dpfd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [THR_BITS-1:0]     cfg_data,
  output cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_scale     <= RST_SAMPLE_SCALE;
      cfg.start_max        <= RST_START_MAX;
      cfg.short_long_split <= RST_SHORT_LONG_SPLIT;
      cfg.short_min        <= RST_SHORT_MIN;
      cfg.long_min         <= RST_LONG_MIN;
      cfg.long_max         <= RST_LONG_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SAMPLE_SCALE:     cfg.sample_scale     <= cfg_data[SCALE_BITS-1:0];
        CFG_START_MAX:        cfg.start_max        <= cfg_data;
        CFG_SHORT_LONG_SPLIT: cfg.short_long_split <= cfg_data;
        CFG_SHORT_MIN:        cfg.short_min        <= cfg_data;
        CFG_LONG_MIN:         cfg.long_min         <= cfg_data;
        CFG_LONG_MAX:         cfg.long_max         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/core/dpfd_pulse_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse evaluator
// Scales both half-bit durations and checks them against the windows.
// ----------------------------------------------------------------------------
module dpfd_pulse_eval
  import dpfd_pkg::*;
#(
  parameter int DURATION_BITS = 16
) (
  input  logic [DURATION_BITS-1:0] first_raw,
  input  logic [DURATION_BITS-1:0] second_raw,
  input  cfg_t                     cfg,
  output eval_t                    eval
);

  localparam int SCALED_BITS = DURATION_BITS + SCALE_BITS;

  logic [SCALED_BITS-1:0] f_us;
  logic [SCALED_BITS-1:0] s_us;
  logic [SCALED_BITS-1:0] start_max_w;
  logic [SCALED_BITS-1:0] split_w;
  logic [SCALED_BITS-1:0] short_min_w;
  logic [SCALED_BITS-1:0] long_min_w;
  logic [SCALED_BITS-1:0] long_max_w;

  assign f_us = SCALED_BITS'(first_raw) * SCALED_BITS'(cfg.sample_scale);
  assign s_us = SCALED_BITS'(second_raw) * SCALED_BITS'(cfg.sample_scale);

  assign start_max_w = SCALED_BITS'(cfg.start_max);
  assign split_w     = SCALED_BITS'(cfg.short_long_split);
  assign short_min_w = SCALED_BITS'(cfg.short_min);
  assign long_min_w  = SCALED_BITS'(cfg.long_min);
  assign long_max_w  = SCALED_BITS'(cfg.long_max);

  always_comb begin
    eval.start_long = s_us > start_max_w;
    eval.bit_one    = !(f_us < split_w);
    eval.pair_err   = ST_OK;
    if (f_us < split_w) begin
      priority if (f_us < short_min_w) begin
        eval.pair_err = ST_SHORT;
      end else if (s_us < split_w) begin
        eval.pair_err = ST_MANCH;
      end else begin
        eval.pair_err = ST_OK;
      end
    end else begin
      priority if (s_us > long_min_w) begin
        eval.pair_err = ST_MANCH;
      end else if (f_us < long_min_w) begin
        eval.pair_err = ST_SHORT;
      end else if (f_us > long_max_w) begin
        eval.pair_err = ST_LONG;
      end else begin
        eval.pair_err = ST_OK;
      end
    end
  end

endmodule

@@ rtl/core/doorbell_pulse_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Doorbell pulse frame decoder
// Decodes 26-pulse doorbell frames into a status, an address and a chime.
// ----------------------------------------------------------------------------
// Each input word carries one pulse duration in sample units and a frame_end
// flag on the last pulse of a frame. Only the word with frame_end set produces
// an output word: status, 8-bit address and 4-bit chime. Address and chime are
// zero unless the status is ok. The configuration channel writes the sample
// scale and window thresholds by index; it is always ready and should only be
// used while no frame word is in flight.
// An accepted word is held in an input register, evaluated against the frame
// state, and its result lands in the output register. Throughput is one word
// per cycle while the output is not stalled; the evaluation stage is a single
// pass through the two duration multipliers and the window compares.
// Reset returns the thresholds to their defaults and clears the frame state.
// When the receiver stalls, the output word holds; the input register keeps
// one more word, after which in_ready drops until the output is taken.
// ----------------------------------------------------------------------------
module doorbell_pulse_frame_decoder
  import dpfd_pkg::*;
#(
  parameter int DURATION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [THR_BITS-1:0]      cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DURATION_BITS-1:0] duration,
  input  logic                     frame_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               status,
  output logic [7:0]               address,
  output logic [3:0]               chime
);

  cfg_t  cfg;
  eval_t eval;

  logic                     v1;
  logic [DURATION_BITS-1:0] dur1;
  logic                     last1;

  logic [INDEX_BITS-1:0]    pulse_index;
  logic [DURATION_BITS-1:0] first_half;
  logic [CODE_BITS-1:0]     code_shift;
  status_t                  first_error;

  logic                     adv;
  logic                     go;
  logic [INDEX_BITS-1:0]    pulse_index_next;
  logic                     is_start;
  logic                     is_pair;
  logic                     is_first;
  status_t                  err_now;
  status_t                  first_error_next;
  logic [CODE_BITS-1:0]     code_shift_next;
  logic [DURATION_BITS-1:0] first_half_next;
  status_t                  status_next;

  dpfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpfd_pulse_eval #(
    .DURATION_BITS (DURATION_BITS)
  ) u_eval (
    .first_raw  (first_half),
    .second_raw (dur1),
    .cfg        (cfg),
    .eval       (eval)
  );

  assign adv      = !out_valid || out_ready;
  assign go       = v1 && adv;
  assign in_ready = !v1 || adv;

  always_comb begin
    pulse_index_next = (pulse_index != INDEX_MAX) ? pulse_index + 1'b1 : pulse_index;
    is_start = pulse_index_next == START_PULSE;
    is_pair  = !is_start && (pulse_index_next < FRAME_PULSES) && pulse_index_next[0];
    is_first = !is_start && (pulse_index_next < FRAME_PULSES) && !pulse_index_next[0];

    err_now = ST_OK;
    if (is_start && eval.start_long) begin
      err_now = ST_START;
    end else if (is_pair) begin
      err_now = eval.pair_err;
    end
    first_error_next = (first_error != ST_OK) ? first_error : err_now;

    code_shift_next = is_pair ? {code_shift[CODE_BITS-2:0], eval.bit_one} : code_shift;
    first_half_next = is_first ? dur1 : first_half;

    priority if (pulse_index_next != FRAME_PULSES) begin
      status_next = ST_COUNT;
    end else if (first_error_next != ST_OK) begin
      status_next = first_error_next;
    end else if (code_shift_next == '0) begin
      status_next = ST_ZERO;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_valid && in_ready) begin
      v1 <= 1'b1;
    end else if (go) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dur1  <= duration;
      last1 <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_index <= '0;
      first_half  <= '0;
      code_shift  <= '0;
      first_error <= ST_OK;
    end else if (go) begin
      if (last1) begin
        pulse_index <= '0;
        first_half  <= '0;
        code_shift  <= '0;
        first_error <= ST_OK;
      end else begin
        pulse_index <= pulse_index_next;
        first_half  <= first_half_next;
        code_shift  <= code_shift_next;
        first_error <= first_error_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && last1) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && last1) begin
      status  <= status_next;
      address <= (status_next == ST_OK) ? code_shift_next[CODE_BITS-1:4] : 8'd0;
      chime   <= (status_next == ST_OK) ? code_shift_next[3:0] : 4'd0;
    end
  end

endmodule

@@ rtl/core/dpfd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Doorbell pulse frame decoder checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dpfd_checker
  import dpfd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [7:0] address,
  input logic [3:0] chime
);

  // A stalled output word must hold its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(address)
      && $stable(chime))
    else $error("output word changed while stalled");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> address == 8'd0 && chime == 4'd0)
    else $error("failed frame carries a nonzero address or chime");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> address != 8'd0 || chime != 4'd0)
    else $error("ok status with an all-zero code");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word present after reset");

endmodule

bind doorbell_pulse_frame_decoder dpfd_checker u_dpfd_checker (.*);
